// ===== src/lpf_pkg.sv =====
// ----------------------------------------------------------------------------
// lpf_pkg
// Shared widths and types for the longest palindrome finder: the item field
// widths used by the channel interfaces and the sequencer state encoding.
// ----------------------------------------------------------------------------
`default_nettype none

package lpf_pkg;

    // Item field widths, fixed by the channel definitions.
    localparam int SYMBOL_W = 8;
    localparam int START_W  = 8;
    localparam int LENGTH_W = 9;

    // Sequencer states, one-hot.
    typedef enum logic [4:0] {
        ST_LOAD  = 5'b00001,
        ST_CHECK = 5'b00010,
        ST_CMP   = 5'b00100,
        ST_SCORE = 5'b01000,
        ST_EMIT  = 5'b10000
    } t_state;

endpackage

`default_nettype wire

// ===== src/lpf_if.sv =====
// ----------------------------------------------------------------------------
// lpf_if
// Valid/ready channels of the longest palindrome finder: the symbol channel
// that carries one string byte per item and the result channel.
// ----------------------------------------------------------------------------
`default_nettype none

interface lpf_sym_if;
    import lpf_pkg::*;

    logic                valid;
    logic                ready;
    logic [SYMBOL_W-1:0] symbol;
    logic                last_symbol;

    modport source (output valid, output symbol, output last_symbol, input ready);
    modport sink   (input valid, input symbol, input last_symbol, output ready);
endinterface

interface lpf_res_if;
    import lpf_pkg::*;

    logic                valid;
    logic                ready;
    logic [START_W-1:0]  start_index;
    logic [LENGTH_W-1:0] run_length;
    logic                overflow;

    modport source (output valid, output start_index, output run_length,
                    output overflow, input ready);
    modport sink   (input valid, input start_index, input run_length,
                    input overflow, output ready);
endinterface

`default_nettype wire

// ===== src/lpf_ram.sv =====
// ----------------------------------------------------------------------------
// lpf_ram
// Generic RAM with one write port and two read ports; both read ports have
// registered outputs, so data appears the cycle after the address.
// ----------------------------------------------------------------------------
`default_nettype none

module lpf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic      [WIDTH-1:0]         o_rdata_a,
    output logic      [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read ports.
    always_ff @(posedge i_clk) begin
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

`default_nettype wire

// ===== src/longest_palindrome_finder_unit.sv =====
// ----------------------------------------------------------------------------
// longest_palindrome_finder_unit
// Buffers a string one byte per item and, after the last byte, finds the
// first longest palindrome by expanding around every odd and even centre.
// Search: after the last byte each centre is widened one matched pair at a
// time; every compare reads both ends of the centre through the two
// registered read ports of the string buffer.
// Throughput: one string at a time; no byte is taken while the search runs.
// Reset: synchronous, active low; clears the sequencer, counts and result
// valid. The string buffer is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module longest_palindrome_finder_unit #(
    parameter int MAX_LEN = 256
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    lpf_sym_if.sink    i_sym,
    lpf_res_if.source  o_res
);
    import lpf_pkg::*;

    localparam int AW = $clog2(MAX_LEN);
    localparam int CW = $clog2(MAX_LEN + 1);

    // Sequencer and search state.
    t_state          r_state,      n_state;
    logic [CW-1:0]   r_fill_count, n_fill_count;
    logic            r_ovf,        n_ovf;
    logic [CW-1:0]   r_best_len,   n_best_len;
    logic [AW-1:0]   r_best_start, n_best_start;
    logic [AW-1:0]   r_i,          n_i;
    logic            r_even,       n_even;
    logic [CW:0]     r_lo,         n_lo;
    logic [CW-1:0]   r_hi,         n_hi;

    // Result register.
    logic                r_out_valid, n_out_valid;
    logic [START_W-1:0]  r_out_start, n_out_start;
    logic [LENGTH_W-1:0] r_out_len,   n_out_len;
    logic                r_out_ovf,   n_out_ovf;

    logic            sym_acc;
    logic            buf_room;
    logic            emit_go;
    logic [CW-1:0]   span_w;
    logic [CW-1:0]   next_i_w;
    logic [SYMBOL_W-1:0] rdata_a;
    logic [SYMBOL_W-1:0] rdata_b;

    // String buffer: written while loading, read at both ends of a centre.
    lpf_ram #(
        .WIDTH (SYMBOL_W),
        .DEPTH (MAX_LEN)
    ) u_text (
        .i_clk     (i_clk),
        .i_we      (sym_acc && buf_room),
        .i_waddr   (r_fill_count[AW-1:0]),
        .i_wdata   (i_sym.symbol),
        .i_raddr_a (r_lo[AW-1:0]),
        .i_raddr_b (r_hi[AW-1:0]),
        .o_rdata_a (rdata_a),
        .o_rdata_b (rdata_b)
    );

    assign i_sym.ready = (r_state == ST_LOAD);
    assign sym_acc     = i_sym.valid && i_sym.ready;
    assign buf_room    = (r_fill_count < CW'(MAX_LEN));
    assign emit_go     = !r_out_valid || o_res.ready;

    // Length of the palindrome between the first failing positions.
    assign span_w   = CW'({1'b0, r_hi} - r_lo - (CW + 1)'(1));
    assign next_i_w = CW'(r_i) + CW'(1);

    // Sequencer next state.
    always_comb begin
        n_state      = r_state;
        n_fill_count = r_fill_count;
        n_ovf        = r_ovf;
        n_best_len   = r_best_len;
        n_best_start = r_best_start;
        n_i          = r_i;
        n_even       = r_even;
        n_lo         = r_lo;
        n_hi         = r_hi;
        n_out_valid  = r_out_valid;
        n_out_start  = r_out_start;
        n_out_len    = r_out_len;
        n_out_ovf    = r_out_ovf;

        if (r_out_valid && o_res.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_LOAD: begin
                if (sym_acc) begin
                    if (buf_room) begin
                        n_fill_count = r_fill_count + CW'(1);
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (i_sym.last_symbol) begin
                        n_i          = '0;
                        n_even       = 1'b0;
                        n_lo         = '0;
                        n_hi         = '0;
                        n_best_len   = CW'(1);
                        n_best_start = '0;
                        n_state      = ST_CHECK;
                    end
                end
            end
            // Both ends inside the string: read them, else the centre ends.
            ST_CHECK: begin
                if (!r_lo[CW] && (r_hi < r_fill_count)) begin
                    n_state = ST_CMP;
                end else begin
                    n_state = ST_SCORE;
                end
            end
            // Matching ends widen the centre by one on each side.
            ST_CMP: begin
                if (rdata_a == rdata_b) begin
                    n_lo    = r_lo - (CW + 1)'(1);
                    n_hi    = r_hi + CW'(1);
                    n_state = ST_CHECK;
                end else begin
                    n_state = ST_SCORE;
                end
            end
            // Keep a strictly longer palindrome, then move to the next centre.
            ST_SCORE: begin
                if (span_w > r_best_len) begin
                    n_best_len   = span_w;
                    n_best_start = AW'(r_lo + (CW + 1)'(1));
                end
                if (!r_even) begin
                    n_even  = 1'b1;
                    n_lo    = {1'b0, CW'(r_i)};
                    n_hi    = next_i_w;
                    n_state = ST_CHECK;
                end else if (next_i_w == r_fill_count) begin
                    n_state = ST_EMIT;
                end else begin
                    n_i     = AW'(next_i_w);
                    n_even  = 1'b0;
                    n_lo    = {1'b0, next_i_w};
                    n_hi    = next_i_w;
                    n_state = ST_CHECK;
                end
            end
            // Hand the result over once the output register is free.
            ST_EMIT: begin
                if (emit_go) begin
                    n_out_valid  = 1'b1;
                    n_out_start  = START_W'(r_best_start);
                    n_out_len    = LENGTH_W'(r_best_len);
                    n_out_ovf    = r_ovf;
                    n_fill_count = '0;
                    n_ovf        = 1'b0;
                    n_best_len   = CW'(1);
                    n_best_start = '0;
                    n_state      = ST_LOAD;
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_LOAD;
            r_fill_count <= '0;
            r_ovf        <= 1'b0;
            r_best_len   <= CW'(1);
            r_best_start <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_fill_count <= n_fill_count;
            r_ovf        <= n_ovf;
            r_best_len   <= n_best_len;
            r_best_start <= n_best_start;
            r_out_valid  <= n_out_valid;
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        r_i         <= n_i;
        r_even      <= n_even;
        r_lo        <= n_lo;
        r_hi        <= n_hi;
        r_out_start <= n_out_start;
        r_out_len   <= n_out_len;
        r_out_ovf   <= n_out_ovf;
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.start_index = r_out_start;
    assign o_res.run_length  = r_out_len;
    assign o_res.overflow    = r_out_ovf;

    // The buffer never holds more bytes than it has entries.
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill_count <= CW'(MAX_LEN))
        else $error("fill count beyond buffer depth");

    // Every centre visited lies inside the stored string.
    a_centre_in_string: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CHECK || r_state == ST_CMP || r_state == ST_SCORE)
        |-> (CW'(r_i) < r_fill_count))
        else $error("centre outside stored string");

    // A handed-over result leaves an empty buffer and a valid output.
    a_emit_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT && emit_go)
        |=> (r_fill_count == '0 && r_out_valid && r_state == ST_LOAD))
        else $error("result hand-over did not clear the string");

endmodule

`default_nettype wire
